FILE: rtl/core/rsam_pkg.sv
// Shared types, constants and the cosine table builder for the rotary speaker block.
// Used by rsam_gain, rsam_lane and rotary_speaker_two_band_am; depends on nothing.
package rsam_pkg;

    localparam int SAMPLE_WIDTH       = 24;
    localparam int COS_TABLE_BITS_DEF = 10;
    localparam int CHANNELS_DEF       = 2;
    localparam int MAX_CHANNELS       = 2;

    localparam int PHASE_W     = 32;
    localparam int Q15_W       = 16;
    localparam int GAIN_W      = 17;
    localparam int Q15_SHIFT   = 15;
    localparam int ONE_Q15     = 32768;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CHAN_W      = 2;

    localparam logic [Q15_W-1:0]  DEPTH_RESET = 16'd26214;
    localparam logic [Q15_W-1:0]  WET_RESET   = 16'd22938;
    localparam logic [Q15_W-1:0]  COEFF_RESET = 16'd2048;
    localparam logic [CHAN_W-1:0] CHAN_RESET  = 2'd2;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HORN_STEP   = 3'd0,
        CFG_WOOFER_STEP = 3'd1,
        CFG_MOD_DEPTH   = 3'd2,
        CFG_WET_MIX     = 3'd3,
        CFG_CROSSOVER   = 3'd4,
        CFG_CHANNELS    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_sample;
        logic signed [SAMPLE_WIDTH-1:0] right_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_out;
        logic signed [SAMPLE_WIDTH-1:0] right_out;
    } out_item_t;

    // One Taylor term: the previous term times t^2, divided by (n+1)(n+2).
    function automatic longint taylor_div(input longint prod, input int n);
        longint q;
        case (n)
            0:       q = prod / 2;
            1:       q = prod / 6;
            2:       q = prod / 12;
            3:       q = prod / 20;
            4:       q = prod / 30;
            5:       q = prod / 42;
            6:       q = prod / 56;
            7:       q = prod / 72;
            8:       q = prod / 90;
            9:       q = prod / 110;
            10:      q = prod / 132;
            11:      q = prod / 156;
            12:      q = prod / 182;
            13:      q = prod / 210;
            14:      q = prod / 240;
            15:      q = prod / 272;
            16:      q = prod / 306;
            17:      q = prod / 342;
            default: q = 0;
        endcase
        return q;
    endfunction

    // Sine (odd) or cosine in Q2.30 for an angle in the first quadrant.
    function automatic longint taylor_q30(input longint t, input bit odd);
        longint t2;
        longint term;
        longint sum;
        int     n;
        int     i;
        t2   = (t * t) >>> 30;
        term = odd ? t : (64'sd1 <<< 30);
        sum  = term;
        n    = odd ? 1 : 0;
        for (i = 0; i < 9; i++) begin
            term = taylor_div((term * t2) >>> 30, n);
            n    = n + 2;
            if (i % 2 == 1) begin
                sum = sum + term;
            end else begin
                sum = sum - term;
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        return sum;
    endfunction

    function automatic longint rnd_q15(input longint v);
        return (v + 64'sd16384) >>> Q15_SHIFT;
    endfunction

    // Table entry k of a table with 2^bits entries over one turn, Q1.15.
    function automatic logic signed [GAIN_W-1:0] cos_entry(input int k, input int bits);
        int     qb;
        int     quarter;
        longint r;
        longint t;
        longint c;
        longint s;
        longint v;
        qb      = bits - 2;
        quarter = (k >> qb) & 3;
        r       = longint'(k & ((1 << qb) - 1));
        t       = (r * HALF_PI_Q30) >>> qb;
        c       = rnd_q15(taylor_q30(t, 1'b0));
        s       = rnd_q15(taylor_q30(t, 1'b1));
        if (c > ONE_Q15) begin
            c = ONE_Q15;
        end
        if (s > ONE_Q15) begin
            s = ONE_Q15;
        end
        case (quarter)
            0:       v = c;
            1:       v = -s;
            2:       v = -c;
            default: v = s;
        endcase
        return GAIN_W'(v);
    endfunction

endpackage

FILE: rtl/core/rotary_speaker_two_band_am.sv
// Top level of the rotary speaker effect: configuration registers, frame control and merge.
// Depends on rsam_pkg, rsam_gain and rsam_lane.
//
// A processed frame (one or two channels) goes from acceptance to the result register,
// and the next frame can be accepted in the cycle after that. The oscillator unit reads the
// cosine ROM, then forms the horn and woofer gains on its one multiplier; the channel lanes
// then run their schedule, each on a single multiplier; the control then moves to the merge,
// which loads the result register. A bypassed frame skips the oscillator unit and the lanes
// and goes straight to the merge. The result register lets a new frame enter while the
// previous result waits; a finished frame holds in the merge until that register is free.
module rotary_speaker_two_band_am #(
    parameter int COS_TABLE_BITS = rsam_pkg::COS_TABLE_BITS_DEF,
    parameter int CHANNELS       = rsam_pkg::CHANNELS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  rsam_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output rsam_pkg::out_item_t              m_data,
    input  logic                             cfg_wr_en,
    input  logic [rsam_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rsam_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import rsam_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_GAIN  = 4'b0010,
        ST_LANE  = 4'b0100,
        ST_MERGE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [PHASE_W-1:0] horn_step_reg;
    logic [PHASE_W-1:0] woofer_step_reg;
    logic [Q15_W-1:0]   depth_reg;
    logic [Q15_W-1:0]   wet_reg;
    logic [Q15_W-1:0]   coeff_reg;
    logic [CHAN_W-1:0]  chan_reg;
    logic [Q15_W-1:0]   cfg_q15;

    in_item_t  in_reg;
    out_item_t out_reg;
    logic      m_valid_reg;
    logic      bypass_reg;
    logic      stereo_reg;

    logic [CHAN_W-1:0] nch;
    logic              accept;
    logic              out_free;
    logic              load_out;
    logic              gain_start;
    logic              lane_start;
    logic              gain_done;
    logic [GAIN_W-1:0] horn_gain;
    logic [GAIN_W-1:0] woofer_gain;
    logic [GAIN_W-1:0] wet_gain;
    logic [GAIN_W-1:0] dry_gain;
    out_item_t         merged;

    logic signed [SAMPLE_WIDTH-1:0] lane_x    [MAX_CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] lane_y    [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0]        lane_done;

    always_comb begin
        if (cfg_wdata[Q15_W-1:0] > Q15_W'(ONE_Q15)) begin
            cfg_q15 = Q15_W'(ONE_Q15);
        end else begin
            cfg_q15 = cfg_wdata[Q15_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            horn_step_reg   <= '0;
            woofer_step_reg <= '0;
            depth_reg       <= DEPTH_RESET;
            wet_reg         <= WET_RESET;
            coeff_reg       <= COEFF_RESET;
            chan_reg        <= CHAN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_HORN_STEP:   horn_step_reg   <= cfg_wdata;
                CFG_WOOFER_STEP: woofer_step_reg <= cfg_wdata;
                CFG_MOD_DEPTH:   depth_reg       <= cfg_q15;
                CFG_WET_MIX:     wet_reg         <= cfg_q15;
                CFG_CROSSOVER:   coeff_reg       <= cfg_q15;
                CFG_CHANNELS:    chan_reg        <= cfg_wdata[CHAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (chan_reg == '0) begin
            nch = '0;
        end else if (chan_reg == CHAN_W'(1) || CHANNELS < 2) begin
            nch = CHAN_W'(1);
        end else begin
            nch = CHAN_W'(2);
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign load_out   = (state_reg == ST_MERGE) && out_free;
    assign gain_start = accept && (nch != '0);
    assign lane_start = (state_reg == ST_GAIN) && gain_done;
    assign wet_gain   = {1'b0, wet_reg};
    assign dry_gain   = GAIN_W'(ONE_Q15) - wet_gain;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (nch == '0) ? ST_MERGE : ST_GAIN;
                end
            end
            ST_GAIN: begin
                if (gain_done) begin
                    state_next = ST_LANE;
                end
            end
            ST_LANE: begin
                if (lane_done[0]) begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            bypass_reg  <= 1'b0;
            stereo_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                bypass_reg <= (nch == '0);
                stereo_reg <= (nch == CHAN_W'(2));
            end
        end
    end

    always_comb begin
        merged.left_out  = bypass_reg ? in_reg.left_sample : lane_y[0];
        merged.right_out = (bypass_reg || !stereo_reg) ? in_reg.right_sample : lane_y[1];
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg <= s_data;
        end
        if (load_out) begin
            out_reg <= merged;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    rsam_gain #(
        .COS_TABLE_BITS(COS_TABLE_BITS)
    ) u_gain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (gain_start),
        .horn_step   (horn_step_reg),
        .woofer_step (woofer_step_reg),
        .depth       (depth_reg),
        .done        (gain_done),
        .horn_gain   (horn_gain),
        .woofer_gain (woofer_gain)
    );

    assign lane_x[0] = in_reg.left_sample;
    assign lane_x[1] = in_reg.right_sample;

    for (genvar ch = 0; ch < MAX_CHANNELS; ch++) begin : g_lane
        if (ch < CHANNELS) begin : g_on
            rsam_lane u_lane (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .start       (lane_start && (ch == 0 || stereo_reg)),
                .x           (lane_x[ch]),
                .coeff       (coeff_reg),
                .woofer_gain (woofer_gain),
                .horn_gain   (horn_gain),
                .dry_gain    (dry_gain),
                .wet_gain    (wet_gain),
                .done        (lane_done[ch]),
                .y           (lane_y[ch])
            );
        end else begin : g_off
            assign lane_done[ch] = 1'b0;
            assign lane_y[ch]    = lane_x[ch];
        end
    end

    a_gain_done_in_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        gain_done |-> state_reg == ST_GAIN)
        else $error("oscillator gains finished outside the gain phase");

    a_lane_done_in_lane: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_done[0] |-> state_reg == ST_LANE)
        else $error("channel lane finished outside the lane phase");

    a_merge_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MERGE && m_valid && !m_ready) |=> state_reg == ST_MERGE)
        else $error("merge left while the result register was still occupied");

    a_accept_idle_lanes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !lane_done[0] && !gain_done)
        else $error("a frame was accepted while a previous frame was still in flight");

endmodule

FILE: rtl/core/rsam_gain.sv
// Horn and woofer oscillators: phase accumulators, cosine ROM and the gain multiplier.
// Depends on rsam_pkg.
module rsam_gain #(
    parameter int COS_TABLE_BITS = rsam_pkg::COS_TABLE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [rsam_pkg::PHASE_W-1:0] horn_step,
    input  logic [rsam_pkg::PHASE_W-1:0] woofer_step,
    input  logic [rsam_pkg::Q15_W-1:0]   depth,
    output logic                         done,
    output logic [rsam_pkg::GAIN_W-1:0]  horn_gain,
    output logic [rsam_pkg::GAIN_W-1:0]  woofer_gain
);
    import rsam_pkg::*;

    localparam int TABLE_SIZE = 1 << COS_TABLE_BITS;
    localparam int NSTEP      = 3;
    localparam int STEP_HORN  = 0;
    localparam int STEP_WOOF  = 1;
    localparam int STEP_LAST  = 2;
    localparam int MUL_W      = Q15_W + GAIN_W;
    localparam int GAIN_SHIFT = 16;

    typedef logic signed [GAIN_W-1:0] cos_rom_t [TABLE_SIZE];

    function automatic cos_rom_t build_rom();
        cos_rom_t rom;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            rom[k] = cos_entry(k, COS_TABLE_BITS);
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_rom();
    localparam logic [MUL_W:0] RND_BIAS = (MUL_W + 1)'(1) << (GAIN_SHIFT - 1);

    logic [PHASE_W-1:0]       horn_phase_reg;
    logic [PHASE_W-1:0]       woofer_phase_reg;
    logic [NSTEP-1:0]         step_reg;
    logic                     done_reg;
    logic signed [GAIN_W-1:0] cos_horn_reg;
    logic signed [GAIN_W-1:0] cos_woof_reg;
    logic [MUL_W-1:0]         prod_reg;
    logic [GAIN_W-1:0]        horn_gain_reg;
    logic [GAIN_W-1:0]        woofer_gain_reg;
    logic signed [GAIN_W:0]   swing_wide;
    logic [GAIN_W-1:0]        swing;
    logic [MUL_W-1:0]         mul_p;
    logic [MUL_W:0]           prod_rnd;
    logic [GAIN_W-1:0]        gain_calc;

    always_comb begin
        if (step_reg[STEP_HORN]) begin
            swing_wide = (GAIN_W + 1)'(ONE_Q15) - (GAIN_W + 1)'(cos_horn_reg);
        end else begin
            swing_wide = (GAIN_W + 1)'(ONE_Q15) - (GAIN_W + 1)'(cos_woof_reg);
        end
        swing     = swing_wide[GAIN_W-1:0];
        mul_p     = MUL_W'(depth) * MUL_W'(swing);
        prod_rnd  = ((MUL_W + 1)'(prod_reg) + RND_BIAS) >> GAIN_SHIFT;
        gain_calc = GAIN_W'(ONE_Q15) - prod_rnd[GAIN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            horn_phase_reg   <= '0;
            woofer_phase_reg <= '0;
            step_reg         <= '0;
            done_reg         <= 1'b0;
        end else begin
            step_reg <= {step_reg[NSTEP-2:0], start};
            done_reg <= step_reg[STEP_LAST];
            if (start) begin
                horn_phase_reg   <= horn_phase_reg + horn_step;
                woofer_phase_reg <= woofer_phase_reg + woofer_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cos_horn_reg <= COS_ROM[horn_phase_reg[PHASE_W-1 -: COS_TABLE_BITS]];
            cos_woof_reg <= COS_ROM[woofer_phase_reg[PHASE_W-1 -: COS_TABLE_BITS]];
        end
        prod_reg <= mul_p;
        if (step_reg[STEP_WOOF]) begin
            horn_gain_reg <= gain_calc;
        end
        if (step_reg[STEP_LAST]) begin
            woofer_gain_reg <= gain_calc;
        end
    end

    assign done        = done_reg;
    assign horn_gain   = horn_gain_reg;
    assign woofer_gain = woofer_gain_reg;

endmodule

FILE: rtl/core/rsam_lane.sv
// One channel lane: crossover filter state, band gains and wet/dry blend on one multiplier.
// Depends on rsam_pkg.
module rsam_lane (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     start,
    input  logic signed [rsam_pkg::SAMPLE_WIDTH-1:0] x,
    input  logic [rsam_pkg::Q15_W-1:0]               coeff,
    input  logic [rsam_pkg::GAIN_W-1:0]              woofer_gain,
    input  logic [rsam_pkg::GAIN_W-1:0]              horn_gain,
    input  logic [rsam_pkg::GAIN_W-1:0]              dry_gain,
    input  logic [rsam_pkg::GAIN_W-1:0]              wet_gain,
    output logic                                     done,
    output logic signed [rsam_pkg::SAMPLE_WIDTH-1:0] y
);
    import rsam_pkg::*;

    localparam int A_W    = SAMPLE_WIDTH + 2;
    localparam int B_W    = GAIN_W + 1;
    localparam int PROD_W = A_W + B_W;
    localparam int NSTEP  = 10;

    localparam int STEP_DIFF     = 0;
    localparam int STEP_FILT_MUL = 1;
    localparam int STEP_LP       = 2;
    localparam int STEP_LOW_MUL  = 3;
    localparam int STEP_HIGH_MUL = 4;
    localparam int STEP_ROT_SUM  = 5;
    localparam int STEP_DRY_MUL  = 6;
    localparam int STEP_WET_MUL  = 7;
    localparam int STEP_MIX_SUM  = 8;
    localparam int STEP_OUT      = 9;

    localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'(1) <<< (Q15_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] OUT_MAX  = (PROD_W'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam logic signed [PROD_W-1:0] OUT_MIN  = -(PROD_W'(1) <<< (SAMPLE_WIDTH - 1));

    logic [NSTEP-1:0]               step_reg;
    logic                           done_reg;
    logic signed [SAMPLE_WIDTH-1:0] lp_reg;
    logic signed [A_W-1:0]          diff_reg;
    logic signed [A_W-1:0]          rot_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [PROD_W-1:0]       acc_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;

    logic signed [A_W-1:0]    mul_a;
    logic signed [B_W-1:0]    mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [PROD_W-1:0] acc_rnd;
    logic signed [A_W-1:0]    lp_sum;
    logic signed [A_W-1:0]    x_minus_lp;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (step_reg[STEP_FILT_MUL]) begin
            mul_a = diff_reg;
            mul_b = $signed({2'b00, coeff});
        end else if (step_reg[STEP_LOW_MUL]) begin
            mul_a = A_W'(lp_reg);
            mul_b = $signed({1'b0, woofer_gain});
        end else if (step_reg[STEP_HIGH_MUL]) begin
            mul_a = diff_reg;
            mul_b = $signed({1'b0, horn_gain});
        end else if (step_reg[STEP_DRY_MUL]) begin
            mul_a = A_W'(x);
            mul_b = $signed({1'b0, dry_gain});
        end else if (step_reg[STEP_WET_MUL]) begin
            mul_a = rot_reg;
            mul_b = $signed({1'b0, wet_gain});
        end
        mul_p      = mul_a * mul_b;
        prod_rnd   = (prod_reg + RND_BIAS) >>> Q15_SHIFT;
        acc_rnd    = (acc_reg + RND_BIAS) >>> Q15_SHIFT;
        lp_sum     = A_W'(lp_reg) + A_W'(prod_rnd);
        x_minus_lp = A_W'(x) - A_W'(lp_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
            lp_reg   <= '0;
        end else begin
            step_reg <= {step_reg[NSTEP-2:0], start};
            done_reg <= step_reg[STEP_OUT];
            if (step_reg[STEP_LP]) begin
                lp_reg <= lp_sum[SAMPLE_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        if (step_reg[STEP_DIFF] || step_reg[STEP_LOW_MUL]) begin
            diff_reg <= x_minus_lp;
        end
        if (step_reg[STEP_HIGH_MUL] || step_reg[STEP_WET_MUL]) begin
            acc_reg <= prod_reg;
        end else if (step_reg[STEP_ROT_SUM] || step_reg[STEP_MIX_SUM]) begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (step_reg[STEP_DRY_MUL]) begin
            rot_reg <= A_W'(acc_rnd);
        end
        if (step_reg[STEP_OUT]) begin
            if (acc_rnd > OUT_MAX) begin
                y_reg <= OUT_MAX[SAMPLE_WIDTH-1:0];
            end else if (acc_rnd < OUT_MIN) begin
                y_reg <= OUT_MIN[SAMPLE_WIDTH-1:0];
            end else begin
                y_reg <= acc_rnd[SAMPLE_WIDTH-1:0];
            end
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the rotary speaker block rotary_speaker_two_band_am.
// Holds its own cycle-free model of the frame math and scoreboards every result against it.
// Depends on rsam_pkg and the block under test; reads no files.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rsam_pkg::*;

    localparam int     TABLE_BITS  = COS_TABLE_BITS_DEF;
    localparam int     TABLE_SIZE  = 1 << TABLE_BITS;
    localparam longint SAMPLE_MAX  = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAMPLE_MIN  = -SAMPLE_MAX - 1;
    localparam int     QUIET_LIMIT = 2000;

    class am_frame_tracker;
        logic [PHASE_W-1:0] horn_step;
        logic [PHASE_W-1:0] woofer_step;
        logic [PHASE_W-1:0] horn_phase;
        logic [PHASE_W-1:0] woofer_phase;
        logic [Q15_W-1:0]   depth_reg;
        logic [Q15_W-1:0]   wet_reg;
        logic [Q15_W-1:0]   coeff_reg;
        logic [CHAN_W-1:0]  chan_reg;
        longint             low_band[2];
        longint             cos_rom[TABLE_SIZE];
        out_item_t          pending_frames[$];
        int                 mismatches;

        function new();
            int     qb;
            int     quarter;
            longint r;
            longint t;
            longint c;
            longint s;
            qb = TABLE_BITS - 2;
            for (int k = 0; k < TABLE_SIZE; k++) begin
                quarter = (k >> qb) & 3;
                r       = longint'(k & ((1 << qb) - 1));
                t       = (r * HALF_PI_Q30) >>> qb;
                c       = round_shift(series_q30(t, 1'b0), Q15_SHIFT);
                s       = round_shift(series_q30(t, 1'b1), Q15_SHIFT);
                if (c > ONE_Q15) c = ONE_Q15;
                if (s > ONE_Q15) s = ONE_Q15;
                case (quarter)
                    0:       cos_rom[k] = c;
                    1:       cos_rom[k] = -s;
                    2:       cos_rom[k] = -c;
                    default: cos_rom[k] = s;
                endcase
            end
            horn_step    = '0;
            woofer_step  = '0;
            horn_phase   = '0;
            woofer_phase = '0;
            depth_reg    = DEPTH_RESET;
            wet_reg      = WET_RESET;
            coeff_reg    = COEFF_RESET;
            chan_reg     = CHAN_RESET;
            low_band[0]  = 0;
            low_band[1]  = 0;
            mismatches   = 0;
        endfunction

        // Rounds half toward plus infinity.
        function longint round_shift(longint v, int sh);
            return (v + (64'sd1 <<< (sh - 1))) >>> sh;
        endfunction

        // Sine (odd) or cosine series in Q2.30 for a first-quadrant angle.
        function longint series_q30(longint t, bit odd);
            longint t2;
            longint term;
            longint acc;
            longint n;
            t2   = (t * t) >>> 30;
            term = odd ? t : (64'sd1 <<< 30);
            acc  = term;
            n    = odd ? 1 : 0;
            for (int i = 0; i < 9; i++) begin
                term = ((term * t2) >>> 30) / ((n + 1) * (n + 2));
                n    = n + 2;
                if (i % 2 == 1) acc = acc + term;
                else            acc = acc - term;
            end
            if (acc < 0) acc = 0;
            return acc;
        endfunction

        function longint clamp_q15(logic [Q15_W-1:0] v);
            return (v > ONE_Q15) ? longint'(ONE_Q15) : longint'(v);
        endfunction

        function logic signed [SAMPLE_WIDTH-1:0] clamp_sample(longint v);
            if (v > SAMPLE_MAX) v = SAMPLE_MAX;
            if (v < SAMPLE_MIN) v = SAMPLE_MIN;
            return v[SAMPLE_WIDTH-1:0];
        endfunction

        function longint band_gain(logic [PHASE_W-1:0] phase, longint depth);
            longint c;
            c = cos_rom[phase >> (PHASE_W - TABLE_BITS)];
            return ONE_Q15 - round_shift(depth * (ONE_Q15 - c), 16);
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_HORN_STEP:   horn_step   = value;
                CFG_WOOFER_STEP: woofer_step = value;
                CFG_MOD_DEPTH:   depth_reg   = value[Q15_W-1:0];
                CFG_WET_MIX:     wet_reg     = value[Q15_W-1:0];
                CFG_CROSSOVER:   coeff_reg   = value[Q15_W-1:0];
                CFG_CHANNELS:    chan_reg    = value[CHAN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_frame(in_item_t frame);
            longint    x[2];
            longint    lp;
            longint    high;
            longint    rot;
            longint    hg;
            longint    wg;
            longint    depth;
            longint    wet;
            longint    coeff;
            int        nch;
            out_item_t res;
            x[0]          = $signed(frame.left_sample);
            x[1]          = $signed(frame.right_sample);
            depth         = clamp_q15(depth_reg);
            wet           = clamp_q15(wet_reg);
            coeff         = clamp_q15(coeff_reg);
            nch           = (chan_reg > 2) ? 2 : int'(chan_reg);
            if (nch > CHANNELS_DEF) nch = CHANNELS_DEF;
            res.left_out  = frame.left_sample;
            res.right_out = frame.right_sample;
            if (nch != 0) begin
                hg = band_gain(horn_phase, depth);
                wg = band_gain(woofer_phase, depth);
                for (int ch = 0; ch < nch; ch++) begin
                    lp           = low_band[ch];
                    lp           = lp + round_shift(coeff * (x[ch] - lp), Q15_SHIFT);
                    low_band[ch] = lp;
                    high         = x[ch] - lp;
                    rot          = round_shift(lp * wg + high * hg, Q15_SHIFT);
                    if (ch == 0) begin
                        res.left_out = clamp_sample(round_shift(
                            x[ch] * (ONE_Q15 - wet) + rot * wet, Q15_SHIFT));
                    end else begin
                        res.right_out = clamp_sample(round_shift(
                            x[ch] * (ONE_Q15 - wet) + rot * wet, Q15_SHIFT));
                    end
                end
                horn_phase   = horn_phase + horn_step;
                woofer_phase = woofer_phase + woofer_step;
            end
            pending_frames.push_back(res);
        endfunction

        function void check_frame(out_item_t got);
            out_item_t exp;
            if (pending_frames.size() == 0) begin
                $error("unexpected result transaction: left_out %0d, right_out %0d",
                       got.left_out, got.right_out);
                mismatches++;
                return;
            end
            exp = pending_frames.pop_front();
            if (got.left_out !== exp.left_out) begin
                $error("left_out: expected %0d, actual %0d", exp.left_out, got.left_out);
                mismatches++;
            end
            if (got.right_out !== exp.right_out) begin
                $error("right_out: expected %0d, actual %0d", exp.right_out, got.right_out);
                mismatches++;
            end
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_HORN_STEP;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    am_frame_tracker tracker;
    bit              no_idle     = 1'b0;
    int              stall_left  = 0;
    int              quiet_count = 0;

    rotary_speaker_two_band_am DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= idle_len();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_frame(m_data);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_count <= 0;
        end else if (quiet_count >= QUIET_LIMIT) begin
            $display("[rotary_speaker_two_band_am] ERROR");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    function automatic in_item_t make_frame(longint left, longint right);
        in_item_t f;
        f.left_sample  = left[SAMPLE_WIDTH-1:0];
        f.right_sample = right[SAMPLE_WIDTH-1:0];
        return f;
    endfunction

    function automatic longint rand_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return longint'($urandom_range(0, 600)) - 300;
            default: return $signed($urandom() & ((1 << SAMPLE_WIDTH) - 1)) << (32 - SAMPLE_WIDTH)
                            >>> (32 - SAMPLE_WIDTH);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_step();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return $urandom();
            2:       return $urandom_range(1, 1 << 24);
            default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_q15();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ONE_Q15;
            2:       return $urandom();
            3:       return $urandom_range(ONE_Q15 + 1, 65535);
            default: return $urandom_range(0, ONE_Q15);
        endcase
    endfunction

    task automatic wait_drained();
        while (tracker.pending_frames.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        tracker.set_register(idx, value);
    endtask

    task automatic load_settings(logic [CFG_DATA_W-1:0] horn, logic [CFG_DATA_W-1:0] woofer,
                                 logic [CFG_DATA_W-1:0] depth, logic [CFG_DATA_W-1:0] wet,
                                 logic [CFG_DATA_W-1:0] coeff, logic [CFG_DATA_W-1:0] chans);
        write_reg(CFG_HORN_STEP, horn);
        write_reg(CFG_WOOFER_STEP, woofer);
        write_reg(CFG_MOD_DEPTH, depth);
        write_reg(CFG_WET_MIX, wet);
        write_reg(CFG_CROSSOVER, coeff);
        write_reg(CFG_CHANNELS, chans);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_frame(in_item_t frame);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= frame;
        do @(posedge aclk); while (!s_ready);
        tracker.note_frame(frame);
    endtask

    task automatic end_phase();
        s_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic random_phase(int count, bit pause_midway);
        logic [CFG_DATA_W-1:0] chans;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: chans = 2;
            6, 7:             chans = 1;
            8:                chans = 0;
            default:          chans = 3;
        endcase
        chans[CFG_DATA_W-1:CHAN_W] = (CFG_DATA_W - CHAN_W)'($urandom());
        no_idle = ($urandom_range(0, 3) == 0);
        load_settings(rand_step(), rand_step(), rand_q15(), rand_q15(), rand_q15(), chans);
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) begin
                end_phase();
            end
            send_frame(make_frame(rand_sample(), rand_sample()));
        end
        end_phase();
    endtask

    initial begin
        tracker = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: phases stay at zero, so the gains sit at full scale.
        send_frame(make_frame(0, 0));
        send_frame(make_frame(SAMPLE_MAX, SAMPLE_MIN));
        send_frame(make_frame(SAMPLE_MIN, SAMPLE_MAX));
        send_frame(make_frame(1, -1));
        send_frame(make_frame(SAMPLE_MAX, SAMPLE_MAX));
        end_phase();

        // Full depth and full wet with a quarter-turn horn step and a three-quarter-turn woofer step.
        load_settings(32'h4000_0000, 32'hC000_0000, ONE_Q15, ONE_Q15, ONE_Q15, 2);
        send_frame(make_frame(SAMPLE_MAX, SAMPLE_MIN));
        send_frame(make_frame(SAMPLE_MIN, SAMPLE_MAX));
        send_frame(make_frame(SAMPLE_MAX, SAMPLE_MIN));
        send_frame(make_frame(SAMPLE_MIN, SAMPLE_MIN));
        send_frame(make_frame(24'sh123456, -24'sd654321));
        end_phase();

        // Left only, with depth and wet above full scale and a frozen crossover.
        load_settings(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_FFFF, 32'h0000_8001, 0, 1);
        send_frame(make_frame(SAMPLE_MAX, SAMPLE_MIN));
        send_frame(make_frame(SAMPLE_MIN, SAMPLE_MAX));
        send_frame(make_frame(-5, 5));
        send_frame(make_frame(4000000, -4000000));
        end_phase();

        // Bypass: frames pass through and no state moves.
        load_settings(32'h1234_5678, 32'h8765_4321, 16384, 0, 1000, 0);
        send_frame(make_frame(SAMPLE_MAX, SAMPLE_MIN));
        send_frame(make_frame(-2, 3));
        send_frame(make_frame(SAMPLE_MIN, SAMPLE_MAX));
        end_phase();

        // The unused channel code acts as stereo; the crossover is above full scale.
        load_settings(32'h0100_0000, 32'h0040_0000, 0, 16384, 32'hFFFF_FFFF, 3);
        send_frame(make_frame(SAMPLE_MAX, SAMPLE_MAX));
        send_frame(make_frame(SAMPLE_MIN, 0));
        send_frame(make_frame(777, -777));
        send_frame(make_frame(0, SAMPLE_MIN));
        end_phase();

        for (int p = 0; p < 8; p++) begin
            random_phase(50, p == 3);
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (40) @(posedge aclk);
        if (tracker.pending_frames.size() != 0) begin
            $error("%0d expected results never arrived", tracker.pending_frames.size());
            tracker.mismatches++;
        end
        if (tracker.mismatches == 0) begin
            $display("[rotary_speaker_two_band_am] OK");
        end else begin
            $display("[rotary_speaker_two_band_am] ERROR");
        end
        $finish;
    end
endmodule

FILE: rotary_speaker_two_band_am.f
rtl/core/rsam_pkg.sv
rtl/core/rsam_gain.sv
rtl/core/rsam_lane.sv
rtl/core/rotary_speaker_two_band_am.sv
bench/testbench.sv
